[hw/rtl/best_offset_prefetcher_defines.svh]
// -----------------------------------------------------------------------------
// Best-offset prefetcher assertion macros
// Concurrent check helpers, clocked on clk and quiet while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef BEST_OFFSET_PREFETCHER_DEFINES_SVH
`define BEST_OFFSET_PREFETCHER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never be seen
`define BOP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[hw/rtl/bop_pkg.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher package
// Shared constants, candidate offset table, FSM and control types.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bop_pkg;

  // geometry
  localparam int BLOCKS_PER_PAGE  = 32;
  localparam int PAGE_BITS        = $clog2(BLOCKS_PER_PAGE);
  localparam int RR_ENTRIES_DEF   = 256;
  localparam int BLOCK_SHIFT_DEF  = 6;
  localparam int TAG_TOP          = 20;
  localparam int ADDR_W           = 64;

  // field widths
  localparam int OFF_W      = PAGE_BITS;
  localparam int DEG_W      = 4;
  localparam int SCORE_W    = 5;
  localparam int ROUND_W    = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DEG_W-1:0]   MAX_DEGREE = DEG_W'(8);
  localparam logic [SCORE_W-1:0] SCORE_CAP  = SCORE_W'(31);

  // register reset values
  localparam logic [DEG_W-1:0]   DEGREE_RST    = DEG_W'(1);
  localparam logic [SCORE_W-1:0] SCORE_MAX_RST = SCORE_W'(31);
  localparam logic [ROUND_W-1:0] ROUND_MAX_RST = ROUND_W'(100);
  localparam logic [SCORE_W-1:0] BAD_SCORE_RST = SCORE_W'(1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE    = 2'd0,
    CFG_SCORE_MAX = 2'd1,
    CFG_ROUND_MAX = 2'd2,
    CFG_BAD_SCORE = 2'd3
  } cfg_reg_t;

  // true when v has no prime factor above five
  function automatic bit is_smooth(int v);
    int p2;
    int p3;
    int p5;
    bit found;
    found = 1'b0;
    p2 = 1;
    for (int a = 0; a < 7; a++) begin
      p3 = p2;
      for (int b = 0; b < 5; b++) begin
        p5 = p3;
        for (int c = 0; c < 4; c++) begin
          if (p5 == v) found = 1'b1;
          p5 = p5 * 5;
        end
        p3 = p3 * 3;
      end
      p2 = p2 * 2;
    end
    return found;
  endfunction

  function automatic int count_cands();
    int n;
    n = 0;
    for (int v = 1; v < BLOCKS_PER_PAGE; v++) begin
      if (is_smooth(v)) n++;
    end
    return n;
  endfunction

  localparam int CAND_N = count_cands();
  localparam int IDX_W  = $clog2(CAND_N);

  typedef logic [OFF_W-1:0] cand_tab_t [CAND_N];

  function automatic cand_tab_t build_cands();
    cand_tab_t t;
    int n;
    t = '{default: '0};
    n = 0;
    for (int v = 1; v < BLOCKS_PER_PAGE; v++) begin
      if (is_smooth(v) && n < CAND_N) begin
        t[n] = OFF_W'(v);
        n++;
      end
    end
    return t;
  endfunction

  // candidate offsets in ascending order
  localparam cand_tab_t CAND_TAB = build_cands();

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_EMIT,
    ST_LOOK,
    ST_LEARN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_en;
    logic fill_wr;
    logic emit_load;
    logic look_rd;
    logic learn_upd;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic in_fill;
    logic in_miss;
    logic emit_ok;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/bop_in_if.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher input channel
// Valid/ready channel carrying one access or fill transaction.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bop_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [bop_pkg::ADDR_W-1:0] address;
  logic                       hit;
  logic                       from_prefetch;

  modport source (output valid, op, address, hit, from_prefetch, input ready);
  modport sink   (input valid, op, address, hit, from_prefetch, output ready);
endinterface

[hw/rtl/bop_out_if.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher result channel
// Valid/ready channel carrying one prefetch request transaction.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bop_out_if;
  logic                       valid;
  logic                       ready;
  logic [bop_pkg::ADDR_W-1:0] prefetch_address;
  logic                       last;

  modport source (output valid, prefetch_address, last, input ready);
  modport sink   (input valid, prefetch_address, last, output ready);
endinterface

[hw/rtl/bop_ctrl.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher controller
// Sequences table clear, fill insert, prefetch issue and offset learning.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bop_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bop_pkg::sts_t sts,
  output bop_pkg::cmd_t cmd
);

  bop_pkg::state_t state_r;
  bop_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bop_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      bop_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) state_nxt = bop_pkg::ST_IDLE;
      end
      bop_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.in_fill) begin
            state_nxt = bop_pkg::ST_FILL;
          end else if (sts.in_miss) begin
            state_nxt = bop_pkg::ST_EMIT;
          end
        end
      end
      bop_pkg::ST_FILL: begin
        cmd.fill_wr = 1'b1;
        state_nxt   = bop_pkg::ST_IDLE;
      end
      bop_pkg::ST_EMIT: begin
        // issue while the output register has room; stop after the last one
        if (!sts.emit_ok) begin
          state_nxt = bop_pkg::ST_LOOK;
        end else if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) state_nxt = bop_pkg::ST_LOOK;
        end
      end
      bop_pkg::ST_LOOK: begin
        cmd.look_rd = 1'b1;
        state_nxt   = bop_pkg::ST_LEARN;
      end
      bop_pkg::ST_LEARN: begin
        cmd.learn_upd = 1'b1;
        state_nxt     = bop_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bop_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/bop_rr_table.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher recent-requests table
// Direct-mapped, xor-hashed tag store with a clearing sweep after reset.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bop_rr_table #(
  parameter int RR_ENTRIES = bop_pkg::RR_ENTRIES_DEF,
  parameter int KEY_W      = bop_pkg::TAG_TOP
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr_en,
  output logic             clr_done,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_key,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_key,
  output logic             rd_hit
);

  localparam int RR_W  = $clog2(RR_ENTRIES);
  localparam int TAG_W = bop_pkg::TAG_TOP - RR_W;

  // entry: valid bit over tag
  logic [TAG_W:0]   mem [RR_ENTRIES];
  logic [RR_W-1:0]  clr_idx_r;
  logic [TAG_W:0]   rd_ent_r;
  logic [TAG_W-1:0] rd_tag_r;

  logic [RR_W-1:0]  wr_idx;
  logic [TAG_W-1:0] wr_tag;
  logic [RR_W-1:0]  rd_idx;
  logic [TAG_W-1:0] rd_tag;

  // xor hash and tag slice
  assign wr_idx = wr_key[RR_W-1:0] ^ wr_key[2*RR_W-1:RR_W];
  assign wr_tag = wr_key[bop_pkg::TAG_TOP-1:RR_W];
  assign rd_idx = rd_key[RR_W-1:0] ^ rd_key[2*RR_W-1:RR_W];
  assign rd_tag = rd_key[bop_pkg::TAG_TOP-1:RR_W];

  // clearing sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (clr_en) begin
      clr_idx_r <= clr_idx_r + RR_W'(1);
    end
  end

  assign clr_done = &clr_idx_r;

  // write port
  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= {1'b1, wr_tag};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ent_r <= mem[rd_idx];
      rd_tag_r <= rd_tag;
    end
  end

  assign rd_hit = rd_ent_r[TAG_W] && (rd_ent_r[TAG_W-1:0] == rd_tag_r);

endmodule

[hw/rtl/bop_datapath.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher datapath
// Item capture, prefetch address generation, offset scoring and config regs.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bop_datapath #(
  parameter int RR_ENTRIES  = bop_pkg::RR_ENTRIES_DEF,
  parameter int BLOCK_SHIFT = bop_pkg::BLOCK_SHIFT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [bop_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bop_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input payload
  input  logic                          in_op,
  input  logic [bop_pkg::ADDR_W-1:0]    in_address,
  input  logic                          in_hit,
  input  logic                          in_from_prefetch,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bop_pkg::ADDR_W-1:0]    out_prefetch_address,
  output logic                          out_last,
  // control
  input  bop_pkg::cmd_t                 cmd,
  output bop_pkg::sts_t                 sts
);

  localparam int BLK_W  = bop_pkg::ADDR_W - BLOCK_SHIFT;
  localparam int RR_W   = $clog2(RR_ENTRIES);
  localparam int KEY_W  = (2 * RR_W > bop_pkg::TAG_TOP) ? 2 * RR_W : bop_pkg::TAG_TOP;
  localparam int POS_W  = bop_pkg::PAGE_BITS + 1;
  localparam int OFF_W  = bop_pkg::OFF_W;
  localparam int SC_W   = bop_pkg::SCORE_W;
  localparam int IDX_W  = bop_pkg::IDX_W;
  localparam int RND_W  = bop_pkg::ROUND_W;
  localparam int DEG_W  = bop_pkg::DEG_W;
  localparam logic [POS_W-1:0] PAGE_END = POS_W'(bop_pkg::BLOCKS_PER_PAGE);

  // configuration registers
  logic [DEG_W-1:0] degree_r;
  logic [SC_W-1:0]  score_max_r;
  logic [RND_W-1:0] round_max_r;
  logic [SC_W-1:0]  bad_score_r;

  // captured transaction
  logic [BLK_W-1:0] block_r;
  logic             pf_r;

  // prefetch generation
  logic [BLK_W-1:0] pf_block_r;
  logic [POS_W-1:0] pos_r;
  logic [DEG_W-1:0] cnt_r;
  logic             out_valid_r;
  logic [BLK_W-1:0] out_block_r;
  logic             out_last_r;

  // learning state
  logic [SC_W-1:0]  score_r [bop_pkg::CAND_N];
  logic [RND_W-1:0] round_r;
  logic [SC_W-1:0]  best_r;
  logic [IDX_W-1:0] test_idx_r;
  logic [OFF_W-1:0] local_best_r;
  logic [OFF_W-1:0] learned_r;
  logic [OFF_W-1:0] active_r;
  logic             look_ok_r;

  logic [BLK_W-1:0]           in_block;
  logic [bop_pkg::PAGE_BITS-1:0] page_off;
  logic [DEG_W-1:0]           lim;
  logic [POS_W-1:0]           pos_next;
  logic [OFF_W-1:0]           test_off;
  logic                       fill_ok;
  logic [KEY_W-1:0]           fill_key;
  logic [KEY_W-1:0]           look_key;
  logic                       rr_hit;
  logic                       clr_done;
  logic                       hit_now;
  logic [SC_W-1:0]            cur_score;
  logic [SC_W-1:0]            inc_score;
  logic [SC_W-1:0]            best_upd;
  logic [OFF_W-1:0]           local_upd;
  logic                       wrap;
  logic [RND_W-1:0]           round_inc;
  logic                       phase_end;
  logic [OFF_W-1:0]           learned_upd;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= bop_pkg::DEGREE_RST;
      score_max_r <= bop_pkg::SCORE_MAX_RST;
      round_max_r <= bop_pkg::ROUND_MAX_RST;
      bad_score_r <= bop_pkg::BAD_SCORE_RST;
    end else if (cfg_we) begin
      unique case (bop_pkg::cfg_reg_t'(cfg_index))
        bop_pkg::CFG_DEGREE:    degree_r    <= cfg_wdata[DEG_W-1:0];
        bop_pkg::CFG_SCORE_MAX: score_max_r <= cfg_wdata[SC_W-1:0];
        bop_pkg::CFG_ROUND_MAX: round_max_r <= cfg_wdata[RND_W-1:0];
        bop_pkg::CFG_BAD_SCORE: bad_score_r <= cfg_wdata[SC_W-1:0];
        default: ;
      endcase
    end
  end

  // decode of the incoming transaction
  assign in_block    = in_address[bop_pkg::ADDR_W-1:BLOCK_SHIFT];
  assign sts.in_fill = in_op;
  assign sts.in_miss = !in_op && !in_hit;

  // capture and prefetch walk
  assign lim      = (degree_r > bop_pkg::MAX_DEGREE) ? bop_pkg::MAX_DEGREE : degree_r;
  assign pos_next = pos_r + POS_W'(active_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      block_r    <= in_block;
      pf_r       <= in_from_prefetch;
      pf_block_r <= in_block + BLK_W'(active_r);
      pos_r      <= POS_W'(in_block[bop_pkg::PAGE_BITS-1:0]) + POS_W'(active_r);
      cnt_r      <= DEG_W'(1);
    end else if (cmd.emit_load) begin
      pf_block_r <= pf_block_r + BLK_W'(active_r);
      pos_r      <= pos_next;
      cnt_r      <= cnt_r + DEG_W'(1);
    end
  end

  assign sts.emit_ok   = (active_r != '0) && (cnt_r <= lim) && (pos_r < PAGE_END);
  assign sts.emit_last = (cnt_r >= lim) || (pos_next >= PAGE_END);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_block_r <= pf_block_r;
      out_last_r  <= sts.emit_last;
    end
  end

  assign sts.out_free          = !out_valid_r || out_ready;
  assign out_valid             = out_valid_r;
  assign out_prefetch_address  = {out_block_r, {BLOCK_SHIFT{1'b0}}};
  assign out_last              = out_last_r;

  // fill insert and candidate lookup keys
  assign page_off = block_r[bop_pkg::PAGE_BITS-1:0];
  assign fill_ok  = ((active_r == '0) ? !pf_r : pf_r) && (page_off >= active_r);
  assign fill_key = block_r[KEY_W-1:0] - KEY_W'(active_r);
  assign test_off = bop_pkg::CAND_TAB[test_idx_r];
  assign look_key = block_r[KEY_W-1:0] - KEY_W'(test_off);

  always_ff @(posedge clk) begin
    if (cmd.look_rd) begin
      look_ok_r <= (page_off >= test_off);
    end
  end

  bop_rr_table #(
    .RR_ENTRIES (RR_ENTRIES),
    .KEY_W      (KEY_W)
  ) u_rr (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_en   (cmd.clr_en),
    .clr_done (clr_done),
    .wr_en    (cmd.fill_wr && fill_ok),
    .wr_key   (fill_key),
    .rd_en    (cmd.look_rd),
    .rd_key   (look_key),
    .rd_hit   (rr_hit)
  );

  assign sts.clr_done = clr_done;

  // score, winner and phase decisions
  always_comb begin
    hit_now   = look_ok_r && rr_hit;
    cur_score = score_r[test_idx_r];
    inc_score = (cur_score == bop_pkg::SCORE_CAP) ? cur_score : cur_score + SC_W'(1);
    best_upd  = best_r;
    local_upd = local_best_r;
    if (hit_now && (inc_score > best_r)) begin
      best_upd  = inc_score;
      local_upd = test_off;
    end
    wrap        = (test_idx_r == IDX_W'(bop_pkg::CAND_N - 1));
    round_inc   = round_r + RND_W'(1);
    phase_end   = wrap && ((best_upd >= score_max_r) || (round_inc == round_max_r));
    learned_upd = (best_upd <= bad_score_r) ? '0 : local_upd;
  end

  // learning state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bop_pkg::CAND_N; k++) score_r[k] <= '0;
      round_r      <= '0;
      best_r       <= '0;
      test_idx_r   <= '0;
      local_best_r <= '0;
      learned_r    <= OFF_W'(1);
      active_r     <= '0;
    end else if (cmd.learn_upd) begin
      test_idx_r <= wrap ? '0 : test_idx_r + IDX_W'(1);
      if (phase_end) begin
        for (int k = 0; k < bop_pkg::CAND_N; k++) score_r[k] <= '0;
        round_r      <= '0;
        best_r       <= '0;
        local_best_r <= '0;
        learned_r    <= learned_upd;
        active_r     <= learned_upd;
      end else begin
        if (hit_now) score_r[test_idx_r] <= inc_score;
        best_r       <= best_upd;
        local_best_r <= local_upd;
        if (wrap) round_r <= round_inc;
        active_r     <= learned_r;
      end
    end
  end

endmodule

[hw/rtl/best_offset_prefetcher.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher
// Issues prefetches at a learned block offset on demand misses.
// -----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Carries
//  in_bus    in   valid/ready    op, address, hit, from_prefetch
//  out_bus   out  valid/ready    prefetch_address, last
//  cfg_*     in   cfg_we only    cfg_index, cfg_wdata (no read-back)
//
//  Hit access: taken in idle, no further step. Fill: capture, table write.
//  Missing access: capture, then one prefetch per cycle through the output
//  register while it has room, a table read on the one read port, a learning update.
//  After reset the table is swept before in_bus.ready rises.
//  A stalled out_bus holds the walk; the last result may wait while the
//  next transaction is taken.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "best_offset_prefetcher_defines.svh"

module best_offset_prefetcher #(
  parameter int RR_ENTRIES  = bop_pkg::RR_ENTRIES_DEF,
  parameter int BLOCK_SHIFT = bop_pkg::BLOCK_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bop_in_if.sink                         in_bus,
  bop_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [bop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bop_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bop_pkg::cmd_t cmd;
  bop_pkg::sts_t sts;
  logic          in_ready;

  bop_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_bus.ready = in_ready;

  bop_datapath #(
    .RR_ENTRIES  (RR_ENTRIES),
    .BLOCK_SHIFT (BLOCK_SHIFT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_op                (in_bus.op),
    .in_address           (in_bus.address),
    .in_hit               (in_bus.hit),
    .in_from_prefetch     (in_bus.from_prefetch),
    .out_valid            (out_bus.valid),
    .out_ready            (out_bus.ready),
    .out_prefetch_address (out_bus.prefetch_address),
    .out_last             (out_bus.last),
    .cmd                  (cmd),
    .sts                  (sts)
  );

  // checks
  `BOP_ASSERT_IMP(a_load_into_free, cmd.emit_load, sts.out_free, "prefetch overwrote a pending result")
  `BOP_ASSERT_NEVER(a_take_during_walk, in_bus.valid && in_bus.ready && cmd.emit_load, "transaction taken during prefetch walk")
  `BOP_ASSERT_NEVER(a_take_during_clear, in_bus.ready && cmd.clr_en, "ready raised during table sweep")

endmodule

[tb/bop_tb_pkg.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher testbench package
// Transaction opcodes shared by the stimulus and the checker.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bop_tb_pkg;

  // input transaction kind
  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_FILL   = 1'b1
  } op_t;

endpackage

[tb/prefetch_checker.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher checker
// Watches the access/fill channel and the register port, keeps its own copy
// of the offset learning state and recent-requests table, and matches every
// prefetch transaction on the result channel against the predicted address
// and last flag, in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefetch_checker
  import bop_pkg::*;
  import bop_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bop_in_if                     in_mon,
  bop_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int PAGE_BLKS = BLOCKS_PER_PAGE;
  localparam int BSHIFT    = BLOCK_SHIFT_DEF;
  localparam int DEG_CAP   = 8;
  localparam int SCORE_SAT = 31;

  typedef struct packed {
    logic [63:0] addr;
    logic        last;
  } pf_req_t;

  // prefetches still owed by the block, oldest first
  pf_req_t     owed_prefetches[$];
  int          errs;

  // register copies
  logic [3:0]  deg_r;
  logic [4:0]  score_lim;
  logic [6:0]  round_lim;
  logic [4:0]  bad_lim;

  // recent-requests table
  logic        rr_ok  [256];
  logic [11:0] rr_key [256];

  // offset learning state
  logic [4:0]  offsets[$];
  logic [4:0]  score [32];
  logic [6:0]  round_cnt;
  logic [4:0]  best;
  logic [4:0]  phase_off;
  logic [4:0]  learned_off;
  logic [4:0]  live_off;
  int unsigned probe;

  function automatic bit is_candidate(int v);
    int n;
    n = v;
    while (n % 2 == 0) n = n / 2;
    while (n % 3 == 0) n = n / 3;
    while (n % 5 == 0) n = n / 5;
    return n == 1;
  endfunction

  // candidate offsets, ascending
  initial begin
    for (int v = 1; v < PAGE_BLKS; v++) begin
      if (is_candidate(v)) offsets = {offsets, 5'(v)};
    end
  end

  // xor-folded index, tag is block bits 19:8
  function automatic logic [7:0] rr_slot(logic [63:0] b);
    return b[7:0] ^ b[15:8];
  endfunction

  function automatic logic rr_has(logic [63:0] b);
    return rr_ok[rr_slot(b)] && (rr_key[rr_slot(b)] == b[19:8]);
  endfunction

  // one offset test per missing access; ends rounds and phases
  task automatic train_offset(logic [63:0] blk, int unsigned pg);
    int unsigned k;
    logic [4:0]  off;
    k = (probe < offsets.size()) ? probe : 0;
    off = offsets[k];
    if (pg >= off && rr_has(blk - 64'(off))) begin
      if (score[k] < SCORE_SAT) score[k] = score[k] + 5'd1;
      if (score[k] > best) begin
        best = score[k];
        phase_off = off;
      end
    end
    probe = (k + 1 >= offsets.size()) ? 0 : k + 1;
    if (probe == 0) begin
      round_cnt = round_cnt + 7'd1;
      if (best >= score_lim || round_cnt == round_lim) begin
        learned_off = (best <= bad_lim) ? 5'd0 : phase_off;
        foreach (score[i]) score[i] = '0;
        phase_off = '0;
        best = '0;
        round_cnt = '0;
      end
    end
    live_off = learned_off;
  endtask

  // prefetches for a missing access, then the learning step
  task automatic predict_access(logic [63:0] blk);
    int unsigned pg;
    int unsigned lim;
    int unsigned n;
    pf_req_t     r;
    pg = blk[4:0];
    lim = (deg_r > DEG_CAP) ? DEG_CAP : deg_r;
    n = 0;
    for (int unsigned i = 1; i <= lim; i++) begin
      if (live_off == 0 || pg + i * live_off >= PAGE_BLKS) break;
      n = i;
    end
    for (int unsigned i = 1; i <= n; i++) begin
      r.addr = (blk + 64'(i * live_off)) << BSHIFT;
      r.last = (i == n);
      owed_prefetches = {owed_prefetches, r};
    end
    train_offset(blk, pg);
  endtask

  // fills insert block minus the live offset, gated on prefetch origin and page position
  task automatic apply_fill(logic [63:0] blk, logic from_pf);
    logic [63:0] base;
    if (live_off == 0 && from_pf) return;
    if (live_off != 0 && !from_pf) return;
    if (blk[4:0] < live_off) return;
    base = blk - 64'(live_off);
    rr_ok[rr_slot(base)] = 1'b1;
    rr_key[rr_slot(base)] = base[19:8];
  endtask

  task automatic check_prefetch();
    pf_req_t want;
    if (owed_prefetches.size() == 0) begin
      errs++;
      $display("%0t: unexpected prefetch: addr %h last %b, none expected",
               $time, out_mon.prefetch_address, out_mon.last);
      return;
    end
    want = owed_prefetches.pop_front();
    if (out_mon.prefetch_address !== want.addr || out_mon.last !== want.last) begin
      errs++;
      $display("%0t: prefetch mismatch: expected addr %h last %b, got addr %h last %b",
               $time, want.addr, want.last, out_mon.prefetch_address, out_mon.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_prefetches.delete();
      errs = 0;
      deg_r = 4'd1;
      score_lim = 5'd31;
      round_lim = 7'd100;
      bad_lim = 5'd1;
      foreach (rr_ok[i]) rr_ok[i] = 1'b0;
      foreach (score[i]) score[i] = '0;
      round_cnt = '0;
      best = '0;
      phase_off = '0;
      learned_off = 5'd1;
      live_off = '0;
      probe = 0;
    end else begin
      // results first: a result never belongs to a transaction of this edge
      if (out_mon.valid && out_mon.ready) check_prefetch();
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_FILL)
          apply_fill(in_mon.address >> BSHIFT, in_mon.from_prefetch);
        else if (!in_mon.hit)
          predict_access(in_mon.address >> BSHIFT);
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DEGREE:    deg_r = cfg_wdata[3:0];
          CFG_SCORE_MAX: score_lim = cfg_wdata[4:0];
          CFG_ROUND_MAX: round_lim = cfg_wdata[6:0];
          CFG_BAD_SCORE: bad_lim = cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
    fail_count <= errs;
    pending <= owed_prefetches.size();
  end

endmodule

[tb/testbench.sv]
// -----------------------------------------------------------------------------
// Best-offset prefetcher testbench
// Drives directed and stream-shaped random access/fill traffic under several
// register settings and idling patterns, including a long result-side stall
// and full drains; the checker beside the block judges every prefetch.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import bop_pkg::*;
  import bop_tb_pkg::*;
;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [63:0] PG_A = 64'h0000_0000_0004_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    chk_fails;
  int                    chk_pending;
  int                    idle_pct;
  int                    stall_pct;
  int                    hold_len;
  logic                  hold_go;
  int                    quiet;

  bop_in_if  in_ch();
  bop_out_if out_ch();

  best_offset_prefetcher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  prefetch_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (chk_fails),
    .pending    (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stalls, plus a long counted hold on request
  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (hold_go != hold_seen) begin
          hold_seen = hold_go;
          hold_left = hold_len;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
      end
    end
  end

  // no transaction on either channel for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] at(logic [63:0] page, int pos, int low);
    return page | (64'(pos % 32) << 6) | 64'(low % 64);
  endfunction

  function automatic logic [63:0] pick_page();
    logic [63:0] p;
    case ($urandom_range(4))
      0:       p = 64'h0;
      1:       p = 64'hFFFF_FFFF_FFFF_F800;
      2:       p = PG_A;
      3:       p = 64'h0000_0000_0010_0800;
      default: p = {$urandom, $urandom};
    endcase
    p[10:0] = '0;
    return p;
  endfunction

  // offer one transaction, with an optional idle gap in front
  task automatic send_item(op_t op, logic [63:0] addr, logic hit, logic pf);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.address <= addr;
    in_ch.hit <= hit;
    in_ch.from_prefetch <= pf;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering, wait for every owed prefetch, then let the block go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(v);
    @(posedge clk);
  endtask

  task automatic set_regs(int unsigned deg, int unsigned smax, int unsigned rmax,
                          int unsigned bad);
    put_reg(CFG_DEGREE, deg);
    put_reg(CFG_SCORE_MAX, smax);
    put_reg(CFG_ROUND_MAX, rmax);
    put_reg(CFG_BAD_SCORE, bad);
    cfg_we <= 1'b0;
  endtask

  // mostly strided miss streams within one page with fills trailing them,
  // some random noise; hit accesses inside the streams are not counted
  task automatic run_traffic(int unsigned budget);
    int unsigned sent;
    logic [63:0] page;
    int unsigned pos;
    int unsigned stride;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 15) begin
        send_item(op_t'($urandom_range(1)), {$urandom, $urandom},
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        page = pick_page();
        stride = $urandom_range(1, 5);
        pos = $urandom_range(31);
        len = $urandom_range(6, 14);
        for (int j = 0; j < len && sent < budget; j++) begin
          if ($urandom_range(99) < 8) begin
            send_item(OP_ACCESS, at(page, pos, $urandom_range(63)), 1'b1,
                      1'($urandom_range(1)));
          end else begin
            send_item(OP_ACCESS, at(page, pos, $urandom_range(63)), 1'b0,
                      1'($urandom_range(1)));
            sent++;
          end
          if ($urandom_range(99) < 65) begin
            send_item(OP_FILL, at(page, pos + $urandom_range(3), $urandom_range(63)),
                      1'($urandom_range(1)), ($urandom_range(99) < 75));
            sent++;
          end
          pos = (pos + stride) % 32;
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_ACCESS;
    in_ch.address <= '0;
    in_ch.hit <= 1'b0;
    in_ch.from_prefetch <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DEGREE;
    cfg_wdata <= '0;
    hold_go <= 1'b0;
    hold_len = 0;
    idle_pct = 0;
    stall_pct <= 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values: fill gating while the offset is zero,
    // ignored hits, zero offset, page end, page test on fills, all-ones address
    send_item(OP_FILL, at(PG_A, 5, 3), 1'b0, 1'b0);
    send_item(OP_FILL, at(PG_A, 9, 0), 1'b0, 1'b1);
    send_item(OP_ACCESS, 64'h0, 1'b1, 1'b0);
    send_item(OP_ACCESS, 64'h0, 1'b0, 1'b0);
    send_item(OP_ACCESS, at(PG_A, 7, 63), 1'b0, 1'b1);
    send_item(OP_ACCESS, at(PG_A, 31, 17), 1'b0, 1'b0);
    send_item(OP_FILL, at(PG_A, 0, 0), 1'b0, 1'b1);
    send_item(OP_FILL, at(PG_A, 9, 5), 1'b0, 1'b1);
    send_item(OP_FILL, at(PG_A, 12, 5), 1'b0, 1'b0);
    send_item(OP_ACCESS, '1, 1'b0, 1'b1);
    send_item(OP_FILL, '1, 1'b1, 1'b1);
    send_item(OP_ACCESS, '1, 1'b1, 1'b0);
    send_item(OP_ACCESS, 64'h8000_0000_0000_00C5, 1'b0, 1'b0);
    settle();

    // degree above eight, full burst and a burst cut by the page end
    set_regs(15, 31, 100, 1);
    send_item(OP_ACCESS, at(PG_A, 0, 1), 1'b0, 1'b0);
    send_item(OP_ACCESS, at(PG_A, 28, 2), 1'b0, 1'b0);
    settle();

    // degree zero
    set_regs(0, 31, 100, 1);
    send_item(OP_ACCESS, at(PG_A, 4, 0), 1'b0, 1'b0);
    settle();

    // no idling; long result hold while the sender keeps offering
    set_regs(8, 31, 1, 0);
    run_traffic(50);
    hold_len = 250;
    hold_go <= ~hold_go;
    run_traffic(30);
    settle();
    run_traffic(25);
    settle();

    // sender idle most cycles
    set_regs(4, 3, 2, 1);
    idle_pct = 81;
    run_traffic(95);
    settle();

    // receiver stalling most cycles
    set_regs(6, 1, 127, 0);
    idle_pct = 0;
    stall_pct <= 81;
    run_traffic(95);
    settle();

    // register extremes: every round ends a phase and turns prefetching off
    set_regs(9, 0, 0, 31);
    stall_pct <= 0;
    run_traffic(20);
    settle();

    // both sides idling
    set_regs(8, 31, 3, 2);
    idle_pct = 36;
    stall_pct <= 36;
    run_traffic(100);
    settle();

    if (chk_fails == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
